### rtl/core/mmfs_pkg.sv
`default_nettype none
package mmfs_pkg;
  localparam int unsigned TableDepth = 16;
  localparam int unsigned MaxModules = 32;
  localparam logic [63:0] NO_FRAME_NUM = 64'hFFFF_FFFF_FFFF_FFFF;

  localparam logic [1:0] CMD_RECORD = 2'd0;
  localparam logic [1:0] CMD_POP    = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;

  localparam logic [1:0] REG_NUM_MODULES = 2'd0;
  localparam logic [1:0] REG_BUF_LIMIT   = 2'd1;
  localparam logic [1:0] REG_LIFETIME    = 2'd2;
  localparam logic [1:0] REG_EXP_MASK    = 2'd3;

  // one table slot as held in a cell
  typedef struct packed {
    logic        valid;
    logic [63:0] frame_num;
    logic [63:0] mask;
    logic [31:0] first_src;
    logic [31:0] extra;
    logic [31:0] arrival;
  } entry_t;
endpackage
`default_nettype wire

### rtl/core/mmfs_cell.sv
`default_nettype none
// one table slot; the row rotates so each slot passes the head position in turn
module mmfs_cell
  import mmfs_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   shift_i,
  input  wire entry_t prev_i,
  output entry_t      entry_o
);
  entry_t payload_q;
  logic   valid_q;
  entry_t entry_d;

  always_comb begin
    entry_d = entry_o;
    if (shift_i) entry_d = prev_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= entry_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    payload_q <= entry_d;
  end

  always_comb begin
    entry_o = payload_q;
    entry_o.valid = valid_q;
  end
endmodule
`default_nettype wire

### rtl/core/multi_module_frame_synchronizer_core.sv
`default_nettype none
// port group  dir  signals
// command     in   start_i, cmd_i, frame_num_i, src_mod_i, frame_extra_i (busy_o is out)
// result      out  done_o, dropped_o, image_valid_o, out_frame_num_o, out_src_mod_o,
//                  out_extra_o
// config      in   cfg_valid_i, cfg_index_i, cfg_data_i (cfg_ready_o is out)
// a record runs the module bit remainder over all 32 source bits, one rotation of the cell
// row (TABLE_DEPTH positions) to expire and gather, one rotation to apply the change and
// the done_o state; a pop skips the remainder, a tick or unused command goes straight to
// the done_o state
// busy_o is high from the accepting edge through the done_o cycle
// reset clears all valid bits and the tick counter at once; no clearing pass
// done_o is high for one cycle with the result; the receiver cannot stall
module multi_module_frame_synchronizer_core
  import mmfs_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TableDepth,
  parameter int unsigned MAX_MODULES = MaxModules
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [1:0]  cmd_i,
  input  wire logic [63:0] frame_num_i,
  input  wire logic [31:0] src_mod_i,
  input  wire logic [31:0] frame_extra_i,
  output logic             done_o,
  output logic             dropped_o,
  output logic             image_valid_o,
  output logic [63:0]      out_frame_num_o,
  output logic [31:0]      out_src_mod_o,
  output logic [31:0]      out_extra_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned PosW = $clog2(TABLE_DEPTH);
  localparam int unsigned ModW = $clog2(MAX_MODULES + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MOD  = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_FIX  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]  state_q, state_d;
  logic [5:0]  num_mod_q;
  logic [3:0]  buf_lim_q;
  logic [31:0] life_q, exp_mask_q, time_q;
  logic [1:0]  cmd_q;
  logic [63:0] id_q;
  logic [31:0] mod_q, extra_q, mod_sh_q;
  logic [5:0]  rem_q;
  logic [5:0]  bitcnt_q;
  logic [PosW-1:0] pos_q;
  logic [CntW-1:0] cnt_q;
  logic        found_q, min_ok_q, ins_pend_q;
  logic [PosW-1:0] fpos_q, mpos_q;
  logic [63:0] min_id_q;
  logic        res_drop_q, res_iv_q;
  logic [63:0] res_id_q;
  logic [31:0] res_mod_q, res_extra_q;

  entry_t    cells [TABLE_DEPTH];
  entry_t    head, head_act, head_new;
  logic      do_shift;

  // effective module count and bit index
  logic [ModW-1:0] n_eff;
  always_comb begin
    if (num_mod_q == 6'd0) n_eff = ModW'(1);
    else if (32'(num_mod_q) > MAX_MODULES) n_eff = ModW'(MAX_MODULES);
    else n_eff = ModW'(num_mod_q);
  end
  logic [63:0] bit_one;
  assign bit_one = 64'd1 << rem_q;

  logic [63:0] new_mask;
  always_comb begin
    new_mask = {32'd0, exp_mask_q};
    if (MAX_MODULES < 64) new_mask = new_mask & ((64'd1 << MAX_MODULES) - 64'd1);
    if (new_mask == 64'd0) begin
      new_mask = (32'(n_eff) >= 32'd64) ? '1 : ((64'd1 << n_eff) - 64'd1);
    end
    new_mask = new_mask & ~bit_one;
  end

  genvar g;
  generate
    for (g = 0; g < TABLE_DEPTH; g = g + 1) begin : g_row
      if (g == 0) begin : g_first
        mmfs_cell u_cell (
          .clk_i  (clk_i),
          .rst_ni (rst_ni),
          .shift_i(do_shift),
          .prev_i (head_new),
          .entry_o(cells[g])
        );
      end else begin : g_rest
        mmfs_cell u_cell (
          .clk_i  (clk_i),
          .rst_ni (rst_ni),
          .shift_i(do_shift),
          .prev_i (cells[g-1]),
          .entry_o(cells[g])
        );
      end
    end
  endgenerate
  // head is the last cell; it feeds cell 0 (possibly modified) on shift
  assign head = cells[TABLE_DEPTH-1];

  logic head_expired;
  assign head_expired = head.valid && ((time_q - head.arrival) > life_q);

  logic in_start;
  assign in_start = start_i && !busy_o;
  logic last_pos;
  assign last_pos = (pos_q == PosW'(TABLE_DEPTH - 1));
  logic over;
  assign over = (32'(cnt_q) > 32'(buf_lim_q)) || (32'(cnt_q) >= 32'(TABLE_DEPTH));
  logic evict;
  assign evict = !found_q && over;

  // second rotation acts on one known position
  logic            act_target;
  logic [PosW-1:0] act_pos;
  always_comb begin
    act_target = 1'b0;
    act_pos = mpos_q;
    if (cmd_q == CMD_POP) begin
      act_target = min_ok_q;
    end else if (found_q) begin
      act_target = 1'b1;
      act_pos = fpos_q;
    end else begin
      act_target = evict;
    end
  end
  logic hit;
  assign hit = (state_q == S_FIX) && act_target && (pos_q == act_pos);

  always_comb begin
    head_act = head;
    if (state_q == S_SCAN && cmd_q == CMD_RECORD && head_expired) head_act.valid = 1'b0;
    if (hit) begin
      if (cmd_q == CMD_POP) begin
        if (head.mask == 64'd0) head_act.valid = 1'b0;
      end else if (found_q) begin
        if ((head.mask & bit_one) == 64'd0) head_act.valid = 1'b0;
        else head_act.mask = head.mask & ~bit_one;
      end else begin
        head_act.valid = 1'b0; // eviction of smallest
      end
    end
  end

  // a new id lands in the first free slot passing the head, the evicted one included
  logic fill;
  assign fill = (state_q == S_FIX) && ins_pend_q && !found_q && !head_act.valid;

  always_comb begin
    head_new = head_act;
    if (fill) begin
      head_new.valid     = 1'b1;
      head_new.frame_num = id_q;
      head_new.mask      = new_mask;
      head_new.first_src = mod_q;
      head_new.extra     = extra_q;
      head_new.arrival   = time_q;
    end
  end
  assign do_shift = (state_q == S_SCAN) || (state_q == S_FIX);

  logic drop_ins;
  assign drop_ins = (32'(cnt_q) + 32'd1 - {31'd0, evict}) > 32'(buf_lim_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_start) begin
        if (cmd_i == CMD_RECORD) state_d = S_MOD;
        else if (cmd_i == CMD_POP) state_d = S_SCAN;
        else state_d = S_DONE;
      end
      S_MOD:  if (bitcnt_q == 6'd1) state_d = S_SCAN;
      S_SCAN: if (last_pos) state_d = S_FIX;
      S_FIX:  if (last_pos) state_d = S_DONE;
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign busy_o = state_q != S_IDLE;
  assign cfg_ready_o = state_q == S_IDLE;

  // restoring remainder, one bit per cycle
  logic [6:0] rem_sh;
  logic [7:0] rem_try;
  assign rem_sh = {rem_q, mod_sh_q[31]};
  assign rem_try = {1'b0, rem_sh} - 8'(n_eff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      num_mod_q  <= 6'd32;
      buf_lim_q  <= 4'd15;
      life_q     <= 32'd1000;
      exp_mask_q <= 32'd0;
      time_q     <= 32'd0;
      pos_q      <= '0;
    end else begin
      state_q    <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          REG_NUM_MODULES: num_mod_q  <= cfg_data_i[5:0];
          REG_BUF_LIMIT:   buf_lim_q  <= cfg_data_i[3:0];
          REG_LIFETIME:    life_q     <= cfg_data_i;
          REG_EXP_MASK:    exp_mask_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_start && cmd_i == CMD_TICK) time_q <= time_q + 32'd1;
      if (state_q == S_IDLE) begin
        pos_q <= '0;
      end else if (do_shift) begin
        pos_q <= last_pos ? '0 : pos_q + PosW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_start) begin
      cmd_q       <= cmd_i;
      id_q        <= frame_num_i;
      mod_q       <= src_mod_i;
      extra_q     <= frame_extra_i;
      mod_sh_q    <= src_mod_i;
      rem_q       <= 6'd0;
      bitcnt_q    <= 6'd32;
      cnt_q       <= '0;
      found_q     <= 1'b0;
      min_ok_q    <= 1'b0;
      min_id_q    <= '1;
      mpos_q      <= '0;
      fpos_q      <= '0;
      ins_pend_q  <= cmd_i == CMD_RECORD;
      res_drop_q  <= 1'b0;
      res_iv_q    <= 1'b0;
      res_id_q    <= NO_FRAME_NUM;
      res_mod_q   <= 32'd0;
      res_extra_q <= 32'd0;
    end
    if (state_q == S_MOD) begin
      bitcnt_q <= bitcnt_q - 6'd1;
      mod_sh_q <= {mod_sh_q[30:0], 1'b0};
      rem_q    <= rem_try[7] ? rem_sh[5:0] : rem_try[5:0];
    end
    // first rotation counts and finds the minimum; on a record it also matches, after expiry
    if (state_q == S_SCAN && head_act.valid) begin
      cnt_q <= cnt_q + CntW'(1);
      if (cmd_q == CMD_RECORD && head_act.frame_num == id_q) begin
        found_q <= 1'b1;
        fpos_q  <= pos_q;
      end
      if (!min_ok_q || head_act.frame_num < min_id_q) begin
        min_ok_q <= 1'b1;
        min_id_q <= head_act.frame_num;
        mpos_q   <= pos_q;
      end
    end
    if (fill) ins_pend_q <= 1'b0;
    if (hit && cmd_q == CMD_POP && head.mask == 64'd0) begin
      res_iv_q    <= 1'b1;
      res_id_q    <= head.frame_num;
      res_mod_q   <= head.first_src;
      res_extra_q <= head.extra;
    end
    if (hit && cmd_q == CMD_RECORD && found_q)
      res_drop_q <= (head.mask & bit_one) == 64'd0;
    if (state_q == S_FIX && last_pos && cmd_q == CMD_RECORD && !found_q)
      res_drop_q <= drop_ins;
  end

  assign done_o          = state_q == S_DONE;
  assign dropped_o       = res_drop_q;
  assign image_valid_o   = res_iv_q;
  assign out_frame_num_o = res_id_q;
  assign out_src_mod_o   = res_mod_q;
  assign out_extra_o     = res_extra_q;
endmodule
`default_nettype wire

### tb/multi_module_frame_synchronizer_core_test.sv
`timescale 1ns / 100ps
module multi_module_frame_synchronizer_core_test
  import mmfs_pkg::*;
;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned CycleLimit = 600000;

  typedef struct {
    logic [1:0]  cmd;
    logic [63:0] frame_num;
    logic [31:0] src_mod;
    logic [31:0] extra;
  } frame_cmd_t;

  typedef struct {
    logic        dropped;
    logic        image_valid;
    logic [63:0] frame_num;
    logic [31:0] src_mod;
    logic [31:0] extra;
  } frame_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic [1:0]  cmd_i = '0;
  logic [63:0] frame_num_i = '0;
  logic [31:0] src_mod_i = '0;
  logic [31:0] frame_extra_i = '0;
  logic        cfg_valid_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        busy_o, done_o, dropped_o, image_valid_o, cfg_ready_o;
  logic [63:0] out_frame_num_o;
  logic [31:0] out_src_mod_o, out_extra_o;

  multi_module_frame_synchronizer_core uut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // shadow of the assembly table
  logic        tbl_valid [TableDepth];
  logic [63:0] tbl_id [TableDepth];
  logic [63:0] tbl_missing [TableDepth];
  logic [31:0] tbl_module [TableDepth];
  logic [31:0] tbl_extra [TableDepth];
  logic [31:0] tbl_arrival [TableDepth];
  logic [31:0] tick_count;
  logic [5:0]  cfg_modules;
  logic [3:0]  cfg_limit;
  logic [31:0] cfg_lifetime;
  logic [31:0] cfg_mask;

  frame_cmd_t  pending_cmds[$];
  frame_res_t  expected_res[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned n_records = 0, n_pops_full = 0, n_drops = 0;
  int unsigned gap = 0;
  bit          quiet = 0;

  function automatic int unsigned modules_used();
    if (cfg_modules == 0) return 1;
    if (cfg_modules > MaxModules) return MaxModules;
    return cfg_modules;
  endfunction

  function automatic int occupancy();
    int c;
    c = 0;
    for (int i = 0; i < TableDepth; i++) if (tbl_valid[i]) c++;
    return c;
  endfunction

  function automatic int oldest_min_id();
    int best;
    best = -1;
    for (int i = 0; i < TableDepth; i++)
      if (tbl_valid[i] && (best < 0 || tbl_id[i] < tbl_id[best])) best = i;
    return best;
  endfunction

  function automatic logic add_record(frame_cmd_t c);
    int unsigned n, bitpos;
    int idx, cnt, m;
    logic [63:0] mask;
    n = modules_used();
    bitpos = c.src_mod % n;
    idx = -1;
    for (int i = 0; i < TableDepth; i++)
      if (tbl_valid[i] && (tick_count - tbl_arrival[i]) > cfg_lifetime) tbl_valid[i] = 1'b0;
    for (int i = 0; i < TableDepth; i++)
      if (idx < 0 && tbl_valid[i] && tbl_id[i] == c.frame_num) idx = i;
    if (idx < 0) begin
      cnt = occupancy();
      if (cnt > cfg_limit || cnt >= TableDepth) begin
        m = oldest_min_id();
        if (m >= 0) tbl_valid[m] = 1'b0;
      end
      for (int i = TableDepth - 1; i >= 0; i--) if (!tbl_valid[i]) idx = i;
      if (idx < 0) return 1'b1;
      mask = {32'd0, cfg_mask};
      if (mask == 0) mask = (n >= 64) ? '1 : ((64'd1 << n) - 1);
      mask &= ~(64'd1 << bitpos);
      tbl_valid[idx] = 1'b1;
      tbl_id[idx] = c.frame_num;
      tbl_missing[idx] = mask;
      tbl_module[idx] = c.src_mod;
      tbl_extra[idx] = c.extra;
      tbl_arrival[idx] = tick_count;
      return occupancy() > cfg_limit;
    end
    if (!tbl_missing[idx][bitpos]) begin
      tbl_valid[idx] = 1'b0;
      return 1'b1;
    end
    tbl_missing[idx][bitpos] = 1'b0;
    return 1'b0;
  endfunction

  function automatic frame_res_t assemble_step(frame_cmd_t c);
    frame_res_t r;
    int m;
    r = '{1'b0, 1'b0, NO_FRAME_NUM, 32'd0, 32'd0};
    case (c.cmd)
      CMD_RECORD: begin
        r.dropped = add_record(c);
        n_records++;
        if (r.dropped) n_drops++;
      end
      CMD_POP: begin
        m = oldest_min_id();
        if (m >= 0 && tbl_missing[m] == 0) begin
          r.image_valid = 1'b1;
          r.frame_num = tbl_id[m];
          r.src_mod = tbl_module[m];
          r.extra = tbl_extra[m];
          tbl_valid[m] = 1'b0;
          n_pops_full++;
        end
      end
      CMD_TICK: tick_count = tick_count + 1;
      default: ;
    endcase
    return r;
  endfunction

  // command driver
  always @(posedge clk_i) begin
    frame_cmd_t c;
    cycles <= cycles + 1;
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        c = '{cmd_i, frame_num_i, src_mod_i, frame_extra_i};
        expected_res.push_back(assemble_step(c));
        if (!quiet && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 4);
      end
      if (!start_i || !busy_o) begin
        if (gap > 0) begin
          gap = gap - 1;
          start_i <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          c = pending_cmds.pop_front();
          start_i <= 1'b1;
          cmd_i <= c.cmd;
          frame_num_i <= c.frame_num;
          src_mod_i <= c.src_mod;
          frame_extra_i <= c.extra;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // result monitor and register write tracking
  always @(posedge clk_i) begin
    frame_res_t e;
    if (rst_ni && cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_NUM_MODULES: cfg_modules = cfg_data_i[5:0];
        REG_BUF_LIMIT:   cfg_limit = cfg_data_i[3:0];
        REG_LIFETIME:    cfg_lifetime = cfg_data_i;
        REG_EXP_MASK:    cfg_mask = cfg_data_i;
        default: ;
      endcase
      cfg_valid_i <= 1'b0;
    end
    if (rst_ni && done_o) begin
      if (expected_res.size() == 0) begin
        $display("%0t: unexpected result beat", $time);
        errors++;
      end else begin
        e = expected_res.pop_front();
        if (e.dropped !== dropped_o || e.image_valid !== image_valid_o ||
            e.frame_num !== out_frame_num_o || e.src_mod !== out_src_mod_o ||
            e.extra !== out_extra_o) begin
          $display("%0t: mismatch exp drop=%b vld=%b id=%h mod=%h ext=%h", $time,
                   e.dropped, e.image_valid, e.frame_num, e.src_mod, e.extra);
          $display("%0t:          got drop=%b vld=%b id=%h mod=%h ext=%h", $time,
                   dropped_o, image_valid_o, out_frame_num_o, out_src_mod_o, out_extra_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("multi_module_frame_synchronizer_core_test: errors");
      $finish;
    end
  end

  task automatic push_cmd(logic [1:0] cmd, logic [63:0] num, logic [31:0] src,
                          logic [31:0] extra);
    pending_cmds.push_back('{cmd, num, src, extra});
  endtask

  // sample between edges so that this edge's driver updates are visible
  task automatic wait_drained();
    @(negedge clk_i);
    while (pending_cmds.size() > 0 || start_i || busy_o || expected_res.size() > 0)
      @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    @(posedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i <= data;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (cfg_valid_i) @(posedge clk_i);
  endtask

  task automatic set_regs(logic [31:0] nm, logic [31:0] lim, logic [31:0] life,
                          logic [31:0] mask);
    write_reg(REG_NUM_MODULES, nm);
    write_reg(REG_BUF_LIMIT, lim);
    write_reg(REG_LIFETIME, life);
    write_reg(REG_EXP_MASK, mask);
  endtask

  // mostly complete images with shuffled module order, plus noise
  task automatic random_traffic(int unsigned count);
    int unsigned done_items, n, k, order[$];
    logic [63:0] id, base;
    base = {$urandom, $urandom} & 64'h0000_0000_0000_ffff;
    done_items = 0;
    while (done_items < count) begin
      if ($urandom_range(0, 99) < 60) begin
        n = (cfg_modules == 0) ? 1 : (cfg_modules > 6 ? 6 : cfg_modules);
        id = base + $urandom_range(0, 5);
        if ($urandom_range(0, 9) == 0) id = {$urandom, $urandom};
        base = base + $urandom_range(0, 3);
        order.delete();
        for (int i = 0; i < n; i++) order.push_back(i);
        order.shuffle();
        if ($urandom_range(0, 7) == 0) order.push_back(order[0]);
        foreach (order[i]) begin
          k = order[i] + modules_used() * $urandom_range(0, 3);
          if ($urandom_range(0, 15) == 0) k = $urandom;
          push_cmd(CMD_RECORD, id, k, $urandom);
          if ($urandom_range(0, 5) == 0) push_cmd(CMD_TICK, '0, '0, '0);
          done_items++;
        end
        repeat ($urandom_range(0, 2)) begin
          push_cmd(CMD_POP, '0, '0, '0);
          done_items++;
        end
      end else begin
        case ($urandom_range(0, 3))
          0: push_cmd(CMD_RECORD, {$urandom, $urandom}, $urandom, $urandom);
          1: push_cmd(CMD_POP, {$urandom, $urandom}, $urandom, $urandom);
          2: push_cmd(CMD_TICK, {$urandom, $urandom}, $urandom, $urandom);
          default: push_cmd(CMD_UNUSED, {$urandom, $urandom}, $urandom, $urandom);
        endcase
        done_items++;
      end
    end
  endtask

  initial begin
    for (int i = 0; i < TableDepth; i++) tbl_valid[i] = 1'b0;
    tick_count = 0;
    cfg_modules = 6'd32;
    cfg_limit = 4'd15;
    cfg_lifetime = 32'd1000;
    cfg_mask = 32'd0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extreme fields, empty pop, unused command, repeats, completion
    set_regs(32'd2, 32'd15, 32'd1000, 32'd0);
    push_cmd(CMD_POP, '0, '0, '0);
    push_cmd(CMD_UNUSED, '1, '1, '1);
    push_cmd(CMD_RECORD, '1, '1, '1);
    push_cmd(CMD_RECORD, '1, 32'd0, '0);
    push_cmd(CMD_RECORD, 64'd0, 32'd0, '1);
    push_cmd(CMD_POP, '0, '0, '0);
    push_cmd(CMD_RECORD, 64'd0, 32'd3, 32'h1234_5678);
    push_cmd(CMD_POP, '0, '0, '0);
    push_cmd(CMD_POP, '0, '0, '0);
    push_cmd(CMD_RECORD, 64'd7, 32'd1, 32'd5);
    push_cmd(CMD_RECORD, 64'd7, 32'd3, 32'd6);
    push_cmd(CMD_POP, '0, '0, '0);
    push_cmd(CMD_TICK, '1, '1, '1);
    wait_drained();

    // out-of-range module counts, tight limits and expiry
    set_regs(32'd0, 32'd0, 32'd0, 32'd0);
    push_cmd(CMD_RECORD, 64'd3, 32'd9, 32'd1);
    push_cmd(CMD_POP, '0, '0, '0);
    push_cmd(CMD_RECORD, 64'd5, 32'd9, 32'd1);
    push_cmd(CMD_RECORD, 64'd4, 32'd9, 32'd1);
    push_cmd(CMD_TICK, '0, '0, '0);
    push_cmd(CMD_RECORD, 64'd8, 32'd9, 32'd1);
    push_cmd(CMD_POP, '0, '0, '0);
    wait_drained();
    set_regs(32'd63, 32'd15, 32'hffff_ffff, 32'hffff_ffff);
    push_cmd(CMD_RECORD, 64'd10, 32'd31, 32'd2);
    push_cmd(CMD_RECORD, 64'd10, 32'd63, 32'd2);
    wait_drained();

    set_regs(32'd4, 32'd15, 32'd1000, 32'd0);
    random_traffic(100);
    wait_drained();
    set_regs(32'd3, 32'd2, 32'd4, 32'd0);
    random_traffic(120);
    wait_drained();
    set_regs(32'd5, 32'd7, 32'd20, 32'h0000_001b);
    random_traffic(100);
    wait_drained();
    set_regs(32'd1, 32'd0, 32'd0, 32'h0000_0001);
    random_traffic(80);
    wait_drained();
    set_regs(32'd6, 32'd15, 32'hffff_ffff, 32'h8000_003f);
    random_traffic(100);
    wait_drained();
    quiet = 1;
    set_regs(32'd2, 32'd4, 32'd8, 32'd0);
    random_traffic(80);
    wait_drained();

    $display("covered %0d records (%0d losses) and %0d complete images over %0d cycles",
             n_records, n_drops, n_pops_full, cycles);
    if (errors == 0) begin
      $display("multi_module_frame_synchronizer_core_test: clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("multi_module_frame_synchronizer_core_test: errors");
    end
    $finish;
  end
endmodule
